// ----- sv/sst_pkg.sv -----
// Shared types and constants for the stereo segment triangulation block.
// No dependencies; every other file of the block imports this package.
package sst_pkg;

  localparam logic [19:0] Z_MAX = 20'hFFFFF;
  localparam logic [20:0] X_MAX = 21'h0FFFFF;
  localparam logic [20:0] X_MIN = 21'h100000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SMALL_DISP = 2'd1,
    ST_HEIGHT     = 2'd2,
    ST_DEGEN      = 2'd3
  } status_t;

  localparam logic [2:0] CFG_FOCAL      = 3'd0;
  localparam logic [2:0] CFG_BASELINE   = 3'd1;
  localparam logic [2:0] CFG_CENTER_X   = 3'd2;
  localparam logic [2:0] CFG_CENTER_ROW = 3'd3;
  localparam logic [2:0] CFG_MIN_DISP   = 3'd4;
  localparam logic [2:0] CFG_MAX_H      = 3'd5;
  localparam logic [2:0] CFG_MIN_H      = 3'd6;
  localparam logic [2:0] CFG_EXTENT     = 3'd7;

  typedef struct packed {
    logic [11:0] focal_px;
    logic [9:0]  baseline_cm;
    logic [14:0] center_x;
    logic [14:0] center_row;
    logic [14:0] min_disparity;
    logic [15:0] max_height_cm;
    logic [15:0] min_height_cm;
    logic [15:0] min_extent;
  } sst_cfg_t;

  // Per-item flags that ride alongside the divider lanes.
  typedef struct packed {
    logic small_disp;
    logic height_rej;
    logic neg1;
    logic neg2;
  } sst_side_t;

endpackage

// ----- sv/stereo_segment_triangulation_top.sv -----
// Top level of the stereo segment triangulation block: configuration registers,
// pipeline enable and the front end, divider and back end. Depends on sst_pkg.
//
//   channel  signals                       direction  transaction
//   in       in_valid/in_ready + 6 fields  sink       one segment pair
//   out      out_valid/out_ready + 5 flds  source     one plan-view result
//   cfg      cfg_valid/cfg_ready, index    sink       one register write
//
// One item per cycle is accepted while the output is not stalled; the divider
// is one-bit-per-stage, with 26 + 2F stages.
// All stages advance together; a stalled result freezes the pipeline, and
// in_ready falls only while out_valid is high and out_ready is low.
// Reset clears the valid bits and loads the register defaults.
module stereo_segment_triangulation_top #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [14:0]        left_x_start,
  input  logic [14:0]        left_y_start,
  input  logic [14:0]        left_x_end,
  input  logic [14:0]        left_y_end,
  input  logic [14:0]        right_x_start,
  input  logic [14:0]        right_x_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [20:0] near_x,
  output logic [19:0]        near_z,
  output logic signed [20:0] far_x,
  output logic [19:0]        far_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sst_pkg::*;

  localparam int DW = 26 + 2 * COORD_FRAC_BITS;

  sst_cfg_t cfg;
  logic     en;

  assign cfg_ready = 1'b1;
  assign en        = out_ready || !out_valid;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_px      <= 12'd1500;
      cfg.baseline_cm   <= 10'd60;
      cfg.center_x      <= 15'd13056;
      cfg.center_row    <= 15'd9856;
      cfg.min_disparity <= 15'd32;
      cfg.max_height_cm <= 16'd1000;
      cfg.min_height_cm <= 16'd5;
      cfg.min_extent    <= 16'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FOCAL:      cfg.focal_px      <= cfg_data[11:0];
        CFG_BASELINE:   cfg.baseline_cm   <= cfg_data[9:0];
        CFG_CENTER_X:   cfg.center_x      <= cfg_data[14:0];
        CFG_CENTER_ROW: cfg.center_row    <= cfg_data[14:0];
        CFG_MIN_DISP:   cfg.min_disparity <= cfg_data[14:0];
        CFG_MAX_H:      cfg.max_height_cm <= cfg_data;
        CFG_MIN_H:      cfg.min_height_cm <= cfg_data;
        CFG_EXTENT:     cfg.min_extent    <= cfg_data;
        default:        cfg.min_extent    <= cfg.min_extent;
      endcase
    end
  end

  logic          fv, dv;
  logic [DW-1:0] num [4];
  logic [DW-1:0] quo [4];
  logic [14:0]   den [2];
  sst_side_t     fside, dside;

  sst_front #(.F(COORD_FRAC_BITS), .DW(DW)) u_front (
    .clk, .rst, .en, .in_valid,
    .left_x_start, .left_y_start, .left_x_end, .left_y_end,
    .right_x_start, .right_x_end,
    .cfg, .out_valid(fv), .num, .den, .side(fside)
  );

  sst_div #(.DW(DW)) u_div (
    .clk, .rst, .en, .in_valid(fv), .num, .den, .side_in(fside),
    .out_valid(dv), .quo, .side_out(dside)
  );

  sst_back #(.DW(DW)) u_back (
    .clk, .rst, .en, .in_valid(dv), .quo, .side(dside),
    .min_extent(cfg.min_extent),
    .out_valid, .status, .near_x, .near_z, .far_x, .far_z
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (near_x == '0 && near_z == '0 && far_x == '0 && far_z == '0))
    else $error("rejected result carries nonzero coordinates");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (near_x <= far_x))
    else $error("accepted result is not ordered by lateral position");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule

// ----- sv/sst_front.sv -----
// Front end: disparities, offsets, products, height band test and dividends.
// Three register stages. Depends on sst_pkg.
module sst_front #(
  parameter int F  = 4,
  parameter int DW = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [14:0]       left_x_start,
  input  logic [14:0]       left_y_start,
  input  logic [14:0]       left_x_end,
  input  logic [14:0]       left_y_end,
  input  logic [14:0]       right_x_start,
  input  logic [14:0]       right_x_end,
  input  sst_pkg::sst_cfg_t cfg,
  output logic              out_valid,
  output logic [DW-1:0]     num [4],
  output logic [14:0]       den [2],
  output sst_pkg::sst_side_t side
);
  import sst_pkg::*;

  // Stage 1: differences.
  logic               v1;
  logic signed [15:0] d1, d2, dx1, dx2, dy1, dy2;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1  <= $signed({1'b0, left_x_start}) - $signed({1'b0, right_x_start});
      d2  <= $signed({1'b0, left_x_end}) - $signed({1'b0, right_x_end});
      dx1 <= $signed({1'b0, left_x_start}) - $signed({1'b0, cfg.center_x});
      dx2 <= $signed({1'b0, left_x_end}) - $signed({1'b0, cfg.center_x});
      dy1 <= $signed({1'b0, cfg.center_row}) - $signed({1'b0, left_y_start});
      dy2 <= $signed({1'b0, cfg.center_row}) - $signed({1'b0, left_y_end});
    end
  end

  // Stage 2: products.
  logic               v2, small2;
  logic signed [25:0] ny1, ny2, nx1, nx2;
  logic signed [32:0] hi1, hi2, lo1, lo2;
  logic [21:0]        fb2;
  logic [14:0]        dm1, dm2;
  logic signed [16:0] mind_s, maxh_s;
  logic signed [10:0] base_s;
  logic signed [15:0] minh_s;

  assign mind_s = $signed({2'b00, cfg.min_disparity});
  assign maxh_s = $signed({1'b0, cfg.max_height_cm});
  assign base_s = $signed({1'b0, cfg.baseline_cm});
  assign minh_s = $signed(cfg.min_height_cm);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      small2 <= (17'(d1) <= mind_s) || (17'(d2) <= mind_s);
      ny1 <= dy1 * base_s;
      ny2 <= dy2 * base_s;
      nx1 <= dx1 * base_s;
      nx2 <= dx2 * base_s;
      hi1 <= maxh_s * d1;
      hi2 <= maxh_s * d2;
      lo1 <= minh_s * d1;
      lo2 <= minh_s * d2;
      fb2 <= 22'(cfg.focal_px) * 22'(cfg.baseline_cm);
      dm1 <= d1[14:0];
      dm2 <= d2[14:0];
    end
  end

  // Stage 3: band test and divider operands.
  logic signed [25:0] nxn1, nxn2;
  logic [24:0]        ax1, ax2;
  logic               above1, above2, below1, below2;

  assign nxn1   = -nx1;
  assign nxn2   = -nx2;
  assign ax1    = nx1[25] ? nxn1[24:0] : nx1[24:0];
  assign ax2    = nx2[25] ? nxn2[24:0] : nx2[24:0];
  assign above1 = 33'(ny1) > hi1;
  assign above2 = 33'(ny2) > hi2;
  assign below1 = 33'(ny1) <= lo1;
  assign below2 = 33'(ny2) <= lo2;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= DW'(fb2) << (2 * F);
      num[1] <= DW'(fb2) << (2 * F);
      num[2] <= DW'(ax1) << F;
      num[3] <= DW'(ax2) << F;
      den[0] <= dm1;
      den[1] <= dm2;
      side.small_disp <= small2;
      side.height_rej <= (above1 && above2) || (below1 && below2);
      side.neg1 <= nx1[25];
      side.neg2 <= nx2[25];
    end
  end

endmodule

// ----- sv/sst_div.sv -----
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Lanes 0 and 2 divide by den[0], lanes 1 and 3 by den[1]. Depends on sst_pkg.
module sst_div #(
  parameter int DW = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DW-1:0]      num [4],
  input  logic [14:0]        den [2],
  input  sst_pkg::sst_side_t side_in,
  output logic               out_valid,
  output logic [DW-1:0]      quo [4],
  output sst_pkg::sst_side_t side_out
);
  import sst_pkg::*;

  // The accumulator shifts dividend bits out at the top and quotient bits in
  // at the bottom, so after the last stage it holds the quotient.
  logic [15:0]   rem_q  [DW][4];
  logic [DW-1:0] acc_q  [DW][4];
  logic [14:0]   den_q  [DW][2];
  sst_side_t     side_q [DW];
  logic          val_q  [DW];

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [15:0]   cur_rem [4];
    logic [DW-1:0] cur_acc [4];
    logic [14:0]   cur_den [2];
    sst_side_t     cur_side;
    logic          cur_val;
    logic [15:0]   trial   [4];
    logic [15:0]   rem_n   [4];
    logic          qbit    [4];

    if (s == 0) begin : g_first
      for (genvar k = 0; k < 4; k++) begin : g_l
        assign cur_rem[k] = '0;
        assign cur_acc[k] = num[k];
      end
      assign cur_den[0] = den[0];
      assign cur_den[1] = den[1];
      assign cur_side   = side_in;
      assign cur_val    = in_valid;
    end else begin : g_next
      for (genvar k = 0; k < 4; k++) begin : g_l
        assign cur_rem[k] = rem_q[s-1][k];
        assign cur_acc[k] = acc_q[s-1][k];
      end
      assign cur_den[0] = den_q[s-1][0];
      assign cur_den[1] = den_q[s-1][1];
      assign cur_side   = side_q[s-1];
      assign cur_val    = val_q[s-1];
    end

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        trial[k] = {cur_rem[k][14:0], cur_acc[k][DW-1]};
        qbit[k]  = trial[k] >= {1'b0, cur_den[k % 2]};
        rem_n[k] = qbit[k] ? trial[k] - {1'b0, cur_den[k % 2]} : trial[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) val_q[s] <= 1'b0;
      else if (en) val_q[s] <= cur_val;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          rem_q[s][k] <= rem_n[k];
          acc_q[s][k] <= {cur_acc[k][DW-2:0], qbit[k]};
        end
        den_q[s][0] <= cur_den[0];
        den_q[s][1] <= cur_den[1];
        side_q[s]   <= cur_side;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_out
    assign quo[k] = acc_q[DW-1][k];
  end
  assign side_out  = side_q[DW-1];
  assign out_valid = val_q[DW-1];

endmodule

// ----- sv/sst_back.sv -----
// Back end: signs, closeness test, saturation, ordering and the output register.
// Three register stages. Depends on sst_pkg.
module sst_back #(
  parameter int DW = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DW-1:0]      quo [4],
  input  sst_pkg::sst_side_t side,
  input  logic [15:0]        min_extent,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic signed [20:0] near_x,
  output logic [19:0]        near_z,
  output logic signed [20:0] far_x,
  output logic [19:0]        far_z
);
  import sst_pkg::*;

  localparam logic signed [DW:0] X_HI = (DW+1)'(1048575);
  localparam logic signed [DW:0] X_LO = ~X_HI;

  // Stage A: signed lateral positions.
  logic               va;
  logic [DW-1:0]      za1, za2;
  logic signed [DW:0] xa1, xa2;
  sst_side_t          sa;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za1 <= quo[0];
      za2 <= quo[1];
      xa1 <= side.neg1 ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});
      xa2 <= side.neg2 ? -$signed({1'b0, quo[3]}) : $signed({1'b0, quo[3]});
      sa  <= side;
    end
  end

  // Stage B: closeness on the exact quotients, order and saturation.
  logic signed [DW+1:0] dxs, adx;
  logic signed [DW:0]   dzs, adz;
  logic                 vb, degb, gtb;
  logic [19:0]          zb1, zb2;
  logic [20:0]          xb1, xb2;
  sst_side_t            sb;

  assign dxs = xa1 - xa2;
  assign adx = dxs[DW+1] ? -dxs : dxs;
  assign dzs = $signed({1'b0, za1}) - $signed({1'b0, za2});
  assign adz = dzs[DW] ? -dzs : dzs;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degb <= ($unsigned(adx) < (DW+2)'(min_extent)) &&
              ($unsigned(adz) < (DW+1)'(min_extent));
      gtb  <= xa1 > xa2;
      zb1  <= (za1 > DW'(Z_MAX)) ? Z_MAX : za1[19:0];
      zb2  <= (za2 > DW'(Z_MAX)) ? Z_MAX : za2[19:0];
      xb1  <= (xa1 > X_HI) ? X_MAX : ((xa1 < X_LO) ? X_MIN : xa1[20:0]);
      xb2  <= (xa2 > X_HI) ? X_MAX : ((xa2 < X_LO) ? X_MIN : xa2[20:0]);
      sb   <= sa;
    end
  end

  // Stage C: status priority and the output register.
  status_t st;

  always_comb begin
    if (sb.small_disp) st = ST_SMALL_DISP;
    else if (sb.height_rej) st = ST_HEIGHT;
    else if (degb) st = ST_DEGEN;
    else st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= st;
      if (st != ST_OK) begin
        near_x <= '0;
        near_z <= '0;
        far_x  <= '0;
        far_z  <= '0;
      end else if (gtb) begin
        near_x <= xb2;
        near_z <= zb2;
        far_x  <= xb1;
        far_z  <= zb1;
      end else begin
        near_x <= xb1;
        near_z <= zb1;
        far_x  <= xb2;
        far_z  <= zb2;
      end
    end
  end

endmodule
